[src/rotate_source_coordinate_defines.svh]
// Assertion macros for the rotate_source_coordinate top level.
`ifndef ROTATE_SOURCE_COORDINATE_DEFINES_SVH
`define ROTATE_SOURCE_COORDINATE_DEFINES_SVH

// Check that post holds on the cycle after pre.
`define RSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("rotate_source_coordinate: next-cycle check failed");

// Check that post holds on the same cycle as pre.
`define RSC_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("rotate_source_coordinate: same-cycle check failed");

`endif

[src/rsc_pkg.sv]
// Shared widths, register indexes and types for the source coordinate rotator.
package rsc_pkg;

    localparam int DIM_W      = 12;
    localparam int MAX_DIM    = 4096;
    localparam int FRAC_BITS  = 8;
    localparam int POS_W      = DIM_W + FRAC_BITS;      // unsigned fixed-point position
    localparam int OFS_W      = POS_W + 1;              // signed offset from center
    localparam int TRIG_W     = 16;
    localparam int TRIG_FRAC  = 14;
    localparam int PROD_W     = OFS_W + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int SQ_W       = 2 * POS_W;              // square of an offset magnitude
    localparam int DIST_W     = SQ_W + 1;
    localparam int RAD_W      = 42;
    localparam int ROT_W      = 24;                     // rounded rotated offset
    localparam int ACC_W      = ROT_W + 1;
    localparam int OUT_W      = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RAD_W;

    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_COLUMN = 3'd0,
        REG_CENTER_ROW    = 3'd1,
        REG_COSINE_TERM   = 3'd2,
        REG_SINE_TERM     = 3'd3,
        REG_LIMIT_ON      = 3'd4,
        REG_LIMIT_RADIUS  = 3'd5
    } t_reg_index;

    typedef struct packed {
        logic [POS_W-1:0]         center_column;
        logic [POS_W-1:0]         center_row;
        logic signed [TRIG_W-1:0] cosine_term;
        logic signed [TRIG_W-1:0] sine_term;
        logic                     limit_on;
        logic [RAD_W-1:0]         radius_sq;
    } t_cfg;

    // Per-stage load enables of the datapath.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

[src/rsc_rotate_core.sv]
// Four-stage rotation datapath: offsets, products, sums and rounding, recentering.
module rsc_rotate_core
    import rsc_pkg::*;
(
    input  logic                    i_clk,
    input  t_cfg                    i_cfg,
    input  t_stage_en               i_en,
    input  logic [DIM_W-1:0]        i_dest_column,
    input  logic [DIM_W-1:0]        i_dest_row,
    output logic signed [OUT_W-1:0] o_source_column,
    output logic signed [OUT_W-1:0] o_source_row,
    output logic                    o_copy_through
);

    localparam logic signed [SUM_W-1:0] RoundHalf = SUM_W'(1) <<< (TRIG_FRAC - 1);
    localparam logic signed [ACC_W-1:0] OutMax    = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OutMin    = -ACC_W'(64'sd1 <<< (OUT_W - 1));

    function automatic logic signed [OUT_W-1:0] f_sat(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > OutMax) begin
            res = OutMax[OUT_W-1:0];
        end else if (v < OutMin) begin
            res = OutMin[OUT_W-1:0];
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

    // Stage 1: clamp, scale to fixed point, subtract center
    logic [DIM_W-1:0]        col_c, row_c;
    logic [POS_W-1:0]        n_x, n_y;
    logic signed [OFS_W-1:0] n_ox, n_oy;
    logic [POS_W-1:0]        r1_x, r1_y;
    logic signed [OFS_W-1:0] r_ox, r_oy;

    always_comb begin
        col_c = i_dest_column;
        row_c = i_dest_row;
        if ({1'b0, i_dest_column} >= (DIM_W + 1)'(MAX_DIM)) begin
            col_c = DIM_W'(MAX_DIM - 1);
        end
        if ({1'b0, i_dest_row} >= (DIM_W + 1)'(MAX_DIM)) begin
            row_c = DIM_W'(MAX_DIM - 1);
        end
        n_x  = {col_c, {FRAC_BITS{1'b0}}};
        n_y  = {row_c, {FRAC_BITS{1'b0}}};
        n_ox = signed'({1'b0, n_x}) - signed'({1'b0, i_cfg.center_column});
        n_oy = signed'({1'b0, n_y}) - signed'({1'b0, i_cfg.center_row});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_x <= n_x;
            r1_y <= n_y;
            r_ox <= n_ox;
            r_oy <= n_oy;
        end
    end

    // Stage 2: four trig products and the two squared offsets
    logic signed [2*OFS_W-1:0] n_sqx_full, n_sqy_full;
    logic signed [PROD_W-1:0]  r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic [SQ_W-1:0]           r_sq_x, r_sq_y;
    logic [POS_W-1:0]          r2_x, r2_y;

    assign n_sqx_full = (2 * OFS_W)'(r_ox) * (2 * OFS_W)'(r_ox);
    assign n_sqy_full = (2 * OFS_W)'(r_oy) * (2 * OFS_W)'(r_oy);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_p_xc <= PROD_W'(r_ox) * PROD_W'(i_cfg.cosine_term);
            r_p_ys <= PROD_W'(r_oy) * PROD_W'(i_cfg.sine_term);
            r_p_xs <= PROD_W'(r_ox) * PROD_W'(i_cfg.sine_term);
            r_p_yc <= PROD_W'(r_oy) * PROD_W'(i_cfg.cosine_term);
            r_sq_x <= n_sqx_full[SQ_W-1:0];
            r_sq_y <= n_sqy_full[SQ_W-1:0];
            r2_x   <= r1_x;
            r2_y   <= r1_y;
        end
    end

    // Stage 3: combine, round half up, radius compare
    logic signed [SUM_W-1:0] n_sum_c, n_sum_r, n_rnd_c, n_rnd_r;
    logic [DIST_W-1:0]       n_dist;
    logic                    n_copy;
    logic signed [ROT_W-1:0] r_rot_c, r_rot_r;
    logic                    r3_copy;
    logic [POS_W-1:0]        r3_x, r3_y;

    always_comb begin
        n_sum_c = SUM_W'(r_p_xc) - SUM_W'(r_p_ys);
        n_sum_r = SUM_W'(r_p_xs) + SUM_W'(r_p_yc);
        n_rnd_c = (n_sum_c + RoundHalf) >>> TRIG_FRAC;
        n_rnd_r = (n_sum_r + RoundHalf) >>> TRIG_FRAC;
        n_dist  = DIST_W'(r_sq_x) + DIST_W'(r_sq_y);
        n_copy  = i_cfg.limit_on && (RAD_W'(n_dist) >= i_cfg.radius_sq);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_rot_c <= n_rnd_c[ROT_W-1:0];
            r_rot_r <= n_rnd_r[ROT_W-1:0];
            r3_copy <= n_copy;
            r3_x    <= r2_x;
            r3_y    <= r2_y;
        end
    end

    // Stage 4: add center back, saturate, pick identity on copy-through
    logic signed [ACC_W-1:0] n_acc_c, n_acc_r;
    logic signed [OUT_W-1:0] n_out_c, n_out_r;
    logic signed [OUT_W-1:0] r_out_c, r_out_r;
    logic                    r_out_copy;

    always_comb begin
        n_acc_c = ACC_W'(signed'({1'b0, i_cfg.center_column})) + ACC_W'(r_rot_c);
        n_acc_r = ACC_W'(signed'({1'b0, i_cfg.center_row})) + ACC_W'(r_rot_r);
        if (r3_copy) begin
            n_out_c = signed'(OUT_W'(r3_x));
            n_out_r = signed'(OUT_W'(r3_y));
        end else begin
            n_out_c = f_sat(n_acc_c);
            n_out_r = f_sat(n_acc_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_out_c    <= n_out_c;
            r_out_r    <= n_out_r;
            r_out_copy <= r3_copy;
        end
    end

    assign o_source_column = r_out_c;
    assign o_source_row    = r_out_r;
    assign o_copy_through  = r_out_copy;

endmodule

[src/rotate_source_coordinate.sv]
// Top level of the source coordinate rotator: handshake, configuration, pipeline control.
// For each destination pixel beat this block returns the source coordinate it is
// resampled from: the destination rotated by the programmed cosine and sine (Q1.14)
// about a fractional center, rounded half up, recentered and saturated to 22 signed
// bits with 8 fraction bits. With the radius limit on, pixels whose squared offset
// reaches the programmed squared radius come back marked copy-through with their own
// coordinate. The datapath is four register stages (offset, multiply, sum and round,
// recenter) that a beat passes through in that order, and one beat is taken every
// clock unless back-pressure has filled them. Each stage loads whenever it is empty
// or the stage after it moves, so a stalled result only blocks input once all four
// stages are full.
// Write configuration only while no beat is in flight; registers apply immediately.
`include "rotate_source_coordinate_defines.svh"

module rotate_source_coordinate
    import rsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // destination coordinate channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [DIM_W-1:0]        i_dest_column,
    input  logic [DIM_W-1:0]        i_dest_row,
    // source coordinate channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_source_column,
    output logic signed [OUT_W-1:0] o_source_row,
    output logic                    o_copy_through
);

    // Configuration registers
    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_CENTER_COLUMN: n_cfg.center_column = i_cfg_data[POS_W-1:0];
                REG_CENTER_ROW:    n_cfg.center_row    = i_cfg_data[POS_W-1:0];
                REG_COSINE_TERM:   n_cfg.cosine_term   = signed'(i_cfg_data[TRIG_W-1:0]);
                REG_SINE_TERM:     n_cfg.sine_term     = signed'(i_cfg_data[TRIG_W-1:0]);
                REG_LIMIT_ON:      n_cfg.limit_on      = i_cfg_data[0];
                REG_LIMIT_RADIUS:  n_cfg.radius_sq     = i_cfg_data[RAD_W-1:0];
                default:           n_cfg = r_cfg;   // unused index: drop the write
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_column <= '0;
            r_cfg.center_row    <= '0;
            r_cfg.cosine_term   <= COS_RESET;
            r_cfg.sine_term     <= '0;
            r_cfg.limit_on      <= 1'b0;
            r_cfg.radius_sq     <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Stage occupancy and advance chain: a stage loads when empty or when
    // the next stage is loading too.
    logic      r_v1, r_v2, r_v3, r_v4;
    t_stage_en adv;
    logic      in_fire;

    always_comb begin
        adv.s4 = !r_v4 || i_out_ready;
        adv.s3 = !r_v3 || adv.s4;
        adv.s2 = !r_v2 || adv.s3;
        adv.s1 = !r_v1 || adv.s2;
    end

    assign o_in_ready  = adv.s1;
    assign in_fire     = i_in_valid && adv.s1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv.s1) begin
                r_v1 <= i_in_valid;
            end
            if (adv.s2) begin
                r_v2 <= r_v1;
            end
            if (adv.s3) begin
                r_v3 <= r_v2;
            end
            if (adv.s4) begin
                r_v4 <= r_v3;
            end
        end
    end

    rsc_rotate_core u_core (
        .i_clk           (i_clk),
        .i_cfg           (r_cfg),
        .i_en            (adv),
        .i_dest_column   (i_dest_column),
        .i_dest_row      (i_dest_row),
        .o_source_column (o_source_column),
        .o_source_row    (o_source_row),
        .o_copy_through  (o_copy_through)
    );

    // Checks
    `RSC_ASSERT_NEXT(a_in_fills_s1, i_clk, i_rst_n, in_fire, r_v1)
    `RSC_ASSERT_NEXT(a_s3_moves_to_s4, i_clk, i_rst_n, r_v3 && adv.s4, r_v4)
    `RSC_ASSERT_NOW(a_full_blocks_in, i_clk, i_rst_n, r_v1 && r_v2 && r_v3 && r_v4 && !i_out_ready, !o_in_ready)
    `RSC_ASSERT_NOW(a_copy_needs_limit, i_clk, i_rst_n, r_v4 && !r_cfg.limit_on, !o_copy_through)
    `RSC_ASSERT_NOW(a_copy_is_identity, i_clk, i_rst_n, r_v4 && o_copy_through, !o_source_column[OUT_W-1] && !o_source_row[OUT_W-1])

endmodule

[sim/source_coordinate_checker.sv]
// Scoreboard for the source coordinate rotator: predicts every beat and checks each result.
module source_coordinate_checker
    import rsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [DIM_W-1:0]        i_dest_column,
    input  logic [DIM_W-1:0]        i_dest_row,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [OUT_W-1:0] i_source_column,
    input  logic signed [OUT_W-1:0] i_source_row,
    input  logic                    i_copy_through,
    output int                      o_fail_count,
    output int                      o_outstanding,
    output int                      o_result_count,
    output int                      o_copy_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     REPORT_LIMIT = 10;
    localparam longint OUT_HI       = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO       = -(64'sd1 <<< (OUT_W - 1));

    typedef struct {
        logic [DIM_W-1:0]        dest_column;
        logic [DIM_W-1:0]        dest_row;
        logic signed [OUT_W-1:0] source_column;
        logic signed [OUT_W-1:0] source_row;
        logic                    copy_through;
    } t_source_beat;

    t_source_beat pending_sources[$];
    t_cfg         rotation;
    int           reports;

    function automatic logic signed [OUT_W-1:0] clip_coordinate(longint value);
        if (value > OUT_HI)
            value = OUT_HI;
        if (value < OUT_LO)
            value = OUT_LO;
        return OUT_W'(value);
    endfunction

    // Add half an LSB, then floor: ties go toward plus infinity.
    function automatic longint round_half_up(longint value);
        return (value + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic t_source_beat rotated_source(logic [DIM_W-1:0] column,
                                                    logic [DIM_W-1:0] row);
        longint       pos_x;
        longint       pos_y;
        longint       cen_x;
        longint       cen_y;
        longint       off_x;
        longint       off_y;
        longint       cos_q;
        longint       sin_q;
        longint unsigned dist_sq;
        t_source_beat beat;
        pos_x = longint'(column) <<< FRAC_BITS;
        pos_y = longint'(row) <<< FRAC_BITS;
        cen_x = longint'(rotation.center_column);
        cen_y = longint'(rotation.center_row);
        cos_q = longint'(rotation.cosine_term);
        sin_q = longint'(rotation.sine_term);
        off_x = pos_x - cen_x;
        off_y = pos_y - cen_y;
        dist_sq = off_x * off_x + off_y * off_y;
        beat.dest_column = column;
        beat.dest_row    = row;
        if (rotation.limit_on && dist_sq >= 64'(rotation.radius_sq)) begin
            // outside the disk: identity map, flagged
            beat.source_column = clip_coordinate(pos_x);
            beat.source_row    = clip_coordinate(pos_y);
            beat.copy_through  = 1'b1;
        end else begin
            beat.source_column = clip_coordinate(cen_x + round_half_up(off_x * cos_q - off_y * sin_q));
            beat.source_row    = clip_coordinate(cen_y + round_half_up(off_x * sin_q + off_y * cos_q));
            beat.copy_through  = 1'b0;
        end
        return beat;
    endfunction

    always @(posedge i_clk) begin
        t_source_beat want;
        if (!i_rst_n) begin
            pending_sources.delete();
            rotation.center_column = '0;
            rotation.center_row    = '0;
            rotation.cosine_term   = COS_RESET;
            rotation.sine_term     = '0;
            rotation.limit_on      = 1'b0;
            rotation.radius_sq     = '0;
            o_fail_count   = 0;
            o_result_count = 0;
            o_copy_count   = 0;
            reports        = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (i_copy_through)
                    o_copy_count++;
                if (pending_sources.size() == 0) begin
                    o_fail_count++;
                    if (reports < REPORT_LIMIT)
                        $display("unexpected result at %0t: col %0d row %0d copy %0b",
                                 $realtime, i_source_column, i_source_row, i_copy_through);
                    reports++;
                end else begin
                    want = pending_sources.pop_front();
                    if (want.source_column !== i_source_column
                        || want.source_row !== i_source_row
                        || want.copy_through !== i_copy_through) begin
                        o_fail_count++;
                        if (reports < REPORT_LIMIT)
                            $display({"mismatch at %0t for dest (%0d,%0d): expected col %0d ",
                                      "row %0d copy %0b, got col %0d row %0d copy %0b"},
                                     $realtime, want.dest_column, want.dest_row,
                                     want.source_column, want.source_row, want.copy_through,
                                     i_source_column, i_source_row, i_copy_through);
                        reports++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pending_sources.push_back(rotated_source(i_dest_column, i_dest_row));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CENTER_COLUMN: rotation.center_column = i_cfg_data[POS_W-1:0];
                    REG_CENTER_ROW:    rotation.center_row    = i_cfg_data[POS_W-1:0];
                    REG_COSINE_TERM:   rotation.cosine_term   = i_cfg_data[TRIG_W-1:0];
                    REG_SINE_TERM:     rotation.sine_term     = i_cfg_data[TRIG_W-1:0];
                    REG_LIMIT_ON:      rotation.limit_on      = i_cfg_data[0];
                    REG_LIMIT_RADIUS:  rotation.radius_sq     = i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = pending_sources.size();
    end

endmodule

[sim/tb.sv]
// Testbench top for the source coordinate rotator: clock, reset, stimulus and verdict.
module tb
    import rsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int MAX_WAIT        = 13;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 8;      // four pipeline stages, doubled
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 100;
    localparam int MAX_PIXEL       = MAX_DIM - 1;
    localparam int MAX_RADIUS_PIX  = 3000;

    localparam logic [CFG_IDX_W-1:0]    SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0]    SPARE_INDEX_HI = 3'd7;
    localparam logic [POS_W-1:0]        CENTER_MAX     = '1;
    localparam logic [POS_W-1:0]        CENTER_MID     = POS_W'(2048 << FRAC_BITS);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE      = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] TRIG_HALF     = 16'sd8192;
    localparam logic signed [TRIG_W-1:0] TRIG_MIN      = 16'sh8000;
    localparam logic signed [TRIG_W-1:0] TRIG_MAX      = 16'sh7FFF;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [DIM_W-1:0]        i_dest_column;
    logic [DIM_W-1:0]        i_dest_row;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [OUT_W-1:0] o_source_column;
    logic signed [OUT_W-1:0] o_source_row;
    logic                    o_copy_through;

    int fail_count;
    int outstanding;
    int result_count;
    int copy_count;
    int beats_sent;
    int settings_used;
    int cycle;
    bit steady = 1'b0;   // when set, neither side idles

    always #CLK_HALF i_clk = ~i_clk;

    rotate_source_coordinate dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_dest_column   (i_dest_column),
        .i_dest_row      (i_dest_row),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_source_column (o_source_column),
        .o_source_row    (o_source_row),
        .o_copy_through  (o_copy_through)
    );

    source_coordinate_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_dest_column   (i_dest_column),
        .i_dest_row      (i_dest_row),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_source_column (o_source_column),
        .i_source_row    (o_source_row),
        .i_copy_through  (o_copy_through),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_result_count  (result_count),
        .o_copy_count    (copy_count)
    );

    // Write one register. Fill the data bits above the register's width with
    // junk so the block has to ignore them; spare indexes get junk only.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] keep;
        int                    reg_width;
        junk = CFG_DATA_W'({$urandom, $urandom});
        case (index)
            REG_CENTER_COLUMN, REG_CENTER_ROW: reg_width = POS_W;
            REG_COSINE_TERM, REG_SINE_TERM:    reg_width = TRIG_W;
            REG_LIMIT_ON:                      reg_width = 1;
            REG_LIMIT_RADIUS:                  reg_width = RAD_W;
            default:                           reg_width = 0;
        endcase
        keep = (CFG_DATA_W'(1) << reg_width) - CFG_DATA_W'(1);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= (value & keep) | (junk & ~keep);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic program_rotation(input logic [POS_W-1:0] pivot_col,
                                    input logic [POS_W-1:0] pivot_row,
                                    input logic signed [TRIG_W-1:0] cos_q,
                                    input logic signed [TRIG_W-1:0] sin_q,
                                    input logic limit,
                                    input logic [RAD_W-1:0] radius_sq);
        write_reg(REG_CENTER_COLUMN, CFG_DATA_W'(pivot_col));
        write_reg(REG_CENTER_ROW,    CFG_DATA_W'(pivot_row));
        write_reg(REG_COSINE_TERM,   CFG_DATA_W'(cos_q));
        write_reg(REG_SINE_TERM,     CFG_DATA_W'(sin_q));
        write_reg(REG_LIMIT_ON,      CFG_DATA_W'(limit));
        write_reg(REG_LIMIT_RADIUS,  CFG_DATA_W'(radius_sq));
        settings_used++;
    endtask

    // Offer one destination pixel and hold it until the block takes it.
    // Valid stays up across back-to-back beats; drop it only for a gap.
    task automatic send_pixel(input int column, input int row);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_dest_column <= DIM_W'(column);
        i_dest_row    <= DIM_W'(row);
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back; with one
    // result per beat the pipeline is empty then, so registers may change.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    function automatic int near_pixel(int anchor, int span);
        int pixel;
        pixel = anchor + int'($urandom_range(0, 2 * span)) - span;
        if (pixel < 0)
            pixel = 0;
        if (pixel > MAX_PIXEL)
            pixel = MAX_PIXEL;
        return pixel;
    endfunction

    // Result side: draw a stall per result, with stretches of no stalls.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        for (cycle = 0; cycle < CYCLE_LIMIT; cycle++)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [POS_W-1:0]         pivot_col;
        logic [POS_W-1:0]         pivot_row;
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
        logic                     limit;
        logic [RAD_W-1:0]         radius_sq;
        int                       radius_fix;
        int                       span;
        int                       column;
        int                       row;
        int                       phase;
        int                       n;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_dest_column = '0;
        i_dest_row    = '0;
        beats_sent    = 0;
        settings_used = 1;   // reset values count as the first setting

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: identity rotation about the origin, no radius limit.
        send_pixel(0, 0);
        send_pixel(MAX_PIXEL, MAX_PIXEL);
        send_pixel(MAX_PIXEL, 0);
        send_pixel(12'hAAA, 12'h555);

        // Half turn about the far corner of the center range.
        settle();
        program_rotation(CENTER_MAX, CENTER_MAX, -TRIG_ONE, '0, 1'b0, '0);
        send_pixel(0, 0);
        send_pixel(MAX_PIXEL, MAX_PIXEL);
        send_pixel(2048, 1);

        // Half-unit trig with an odd center column puts products on exact ties,
        // both above and below zero.
        settle();
        program_rotation(POS_W'(1), '0, TRIG_HALF, -TRIG_HALF, 1'b0, '0);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 3);

        // Trig terms beyond unity: drive the sums past the output range.
        settle();
        program_rotation('0, '0, TRIG_MIN, TRIG_MAX, 1'b0, '0);
        send_pixel(MAX_PIXEL, MAX_PIXEL);
        send_pixel(MAX_PIXEL, 0);
        settle();
        program_rotation(CENTER_MAX, CENTER_MAX, TRIG_MIN, TRIG_MIN, 1'b0, '0);
        send_pixel(0, 0);
        send_pixel(2048, 0);

        // Limit on with a zero radius: every pixel comes back copied through.
        settle();
        program_rotation(CENTER_MID, CENTER_MID, '0, TRIG_ONE, 1'b1, '0);
        send_pixel(2048, 2048);
        send_pixel(0, 0);
        send_pixel(MAX_PIXEL, MAX_PIXEL);

        // Radius of exactly 100 pixels: a pixel on the circle is copied,
        // one just inside is rotated.
        settle();
        write_reg(REG_LIMIT_RADIUS, CFG_DATA_W'(25600 * 25600));
        send_pixel(2148, 2048);
        send_pixel(2147, 2048);
        send_pixel(2048, 1948);
        send_pixel(2048, 2048);

        // Largest radius: nothing reaches it. Then writes to unused indexes,
        // which must leave the setting alone.
        settle();
        write_reg(REG_LIMIT_RADIUS, '1);
        send_pixel(0, 0);
        settle();
        write_reg(SPARE_INDEX_LO, '0);
        write_reg(SPARE_INDEX_HI, '0);
        send_pixel(0, MAX_PIXEL);
        send_pixel(MAX_PIXEL, 0);

        // Random settings, each with a batch of pixels mostly clustered around
        // the center so the radius test goes both ways.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case ($urandom_range(0, 5))
                0: begin cos_q = TRIG_ONE;  sin_q = '0;        end
                1: begin cos_q = '0;        sin_q = TRIG_ONE;  end
                2: begin cos_q = -TRIG_ONE; sin_q = '0;        end
                3: begin cos_q = '0;        sin_q = -TRIG_ONE; end
                4: begin
                    cos_q = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
                    sin_q = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
                end
                default: begin
                    cos_q = TRIG_W'($urandom);
                    sin_q = TRIG_W'($urandom);
                end
            endcase
            case ($urandom_range(0, 5))
                0:       pivot_col = '0;
                1:       pivot_col = CENTER_MAX;
                default: pivot_col = POS_W'($urandom);
            endcase
            pivot_row = ($urandom_range(0, 5) == 0) ? CENTER_MAX : POS_W'($urandom);
            limit = ($urandom_range(0, 2) != 0);
            radius_fix = $urandom_range(0, MAX_RADIUS_PIX << FRAC_BITS);
            radius_sq = RAD_W'(longint'(radius_fix) * longint'(radius_fix));
            if ($urandom_range(0, 7) == 0)
                radius_sq = RAD_W'({$urandom, $urandom});
            program_rotation(pivot_col, pivot_row, cos_q, sin_q, limit, radius_sq);
            span = (radius_fix >> FRAC_BITS) + 40;
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n % 25 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) != 0) begin
                    column = near_pixel(int'(pivot_col >> FRAC_BITS), span);
                    row    = near_pixel(int'(pivot_row >> FRAC_BITS), span);
                end else begin
                    column = $urandom_range(0, MAX_PIXEL);
                    row    = $urandom_range(0, MAX_PIXEL);
                end
                send_pixel(column, row);
            end
        end

        // Drain, then let the pipeline run on to catch any stray result.
        steady = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d destination pixels under %0d rotation settings",
                 beats_sent, settings_used);
        $display("%0d source coordinates checked, %0d of them copied through, %0d failures",
                 result_count, copy_count, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/rsc_pkg.sv
src/rsc_rotate_core.sv
src/rotate_source_coordinate.sv
sim/source_coordinate_checker.sv
sim/tb.sv
